>>> rtl/hcbp_pkg.sv
// shared constants, command codes and transfer structs for the huffman bit packer
package hcbp_pkg;

  // code and alphabet limits
  localparam int MAX_CODE_LEN  = 32;
  localparam int ALPHABET_SIZE = 256;
  localparam int BYTE_BITS     = 8;
  localparam int SYM_BITS      = 8;
  localparam int CODE_BITS     = 32;
  localparam int LEN_BITS      = 6;
  localparam int CODE_LIMIT    = (MAX_CODE_LEN < CODE_BITS) ? MAX_CODE_LEN : CODE_BITS;
  localparam int TBL_AW        = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

  // input bus layout
  localparam int CMD_BITS      = 2;
  localparam int S_DATA_BITS   = 48;

  // job queue between front and back
  localparam int QDEPTH        = 4;
  localparam int QAW           = $clog2(QDEPTH);
  localparam int QCNT_BITS     = $clog2(QDEPTH + 2);

  // bit buffer in the back end: up to seven leftover bits plus one full code
  localparam int BUF_BITS      = CODE_BITS + BYTE_BITS;
  localparam int CNT_BITS      = $clog2(BUF_BITS + 1);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  // one code table entry, code left-aligned
  typedef struct packed {
    logic [LEN_BITS-1:0]  len;
    logic [CODE_BITS-1:0] code;
  } tbl_entry_t;

  localparam int TBL_BITS = $bits(tbl_entry_t);

  // one job for the back end
  typedef struct packed {
    logic                 flush;
    logic [CODE_BITS-1:0] code;
    logic [LEN_BITS-1:0]  len;
  } job_t;

endpackage

>>> rtl/hcbp_ram.sv
// generic single write port ram with registered read
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/hcbp_front.sv
// front end: accepts commands, writes and reads the code table, issues jobs
module hcbp_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // symbol [7:0], code_bits [39:8], code_length [45:40], zero [47:46]
  input  logic [hcbp_pkg::S_DATA_BITS-1:0]  s_tdata,
  // command [1:0]
  input  logic [hcbp_pkg::CMD_BITS-1:0]     s_tuser,
  input  logic [hcbp_pkg::QCNT_BITS-1:0]    q_count,
  output logic                              push,
  output hcbp_pkg::job_t                    push_job
);

  hcbp_pkg::cmd_t                       cmd;
  logic [hcbp_pkg::SYM_BITS-1:0]        sym;
  logic [hcbp_pkg::CODE_BITS-1:0]       bits;
  logic [hcbp_pkg::LEN_BITS-1:0]        len;
  logic [hcbp_pkg::LEN_BITS-1:0]        len_sat;
  logic [hcbp_pkg::LEN_BITS-1:0]        shamt;
  logic                                 accept;
  logic                                 in_range;
  logic                                 is_load;
  logic                                 is_encode;
  logic                                 is_flush;
  hcbp_pkg::tbl_entry_t                 wr_entry;
  hcbp_pkg::tbl_entry_t                 rd_entry;
  logic [hcbp_pkg::TBL_BITS-1:0]        rd_word;
  logic                                 s1_valid;
  logic                                 s1_flush;

  // field unpacking
  assign cmd  = hcbp_pkg::cmd_t'(s_tuser);
  assign sym  = s_tdata[7:0];
  assign bits = s_tdata[39:8];
  assign len  = s_tdata[45:40];

  // credit check: queue entries plus the job in flight must leave a slot
  assign s_tready = (q_count + hcbp_pkg::QCNT_BITS'(s1_valid))
                    < hcbp_pkg::QCNT_BITS'(hcbp_pkg::QDEPTH);
  assign accept   = s_tvalid & s_tready;
  assign in_range = {1'b0, sym} < (hcbp_pkg::SYM_BITS + 1)'(hcbp_pkg::ALPHABET_SIZE);

  // command decode
  always_comb begin
    is_load   = 1'b0;
    is_encode = 1'b0;
    is_flush  = 1'b0;
    unique case (cmd)
      hcbp_pkg::CMD_LOAD:   is_load   = 1'b1;
      hcbp_pkg::CMD_ENCODE: is_encode = 1'b1;
      hcbp_pkg::CMD_FLUSH:  is_flush  = 1'b1;
      default: ;
    endcase
  end

  // saturate length and left-align the code, which also drops bits above len
  assign len_sat = (len > hcbp_pkg::LEN_BITS'(hcbp_pkg::CODE_LIMIT))
                   ? hcbp_pkg::LEN_BITS'(hcbp_pkg::CODE_LIMIT) : len;
  assign shamt   = hcbp_pkg::LEN_BITS'(hcbp_pkg::CODE_BITS) - len_sat;
  assign wr_entry.len  = len_sat;
  assign wr_entry.code = bits << shamt;

  // code table
  hcbp_ram #(
    .WIDTH (hcbp_pkg::TBL_BITS),
    .DEPTH (hcbp_pkg::ALPHABET_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (accept & is_load & in_range),
    .waddr (sym[hcbp_pkg::TBL_AW-1:0]),
    .wdata (wr_entry),
    .re    (accept & is_encode & in_range),
    .raddr (sym[hcbp_pkg::TBL_AW-1:0]),
    .rdata (rd_word)
  );

  assign rd_entry = hcbp_pkg::tbl_entry_t'(rd_word);

  // lookup stage, lines up with the registered table read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_flush <= 1'b0;
    end else begin
      s1_valid <= accept & ((is_encode & in_range) | is_flush);
      s1_flush <= is_flush;
    end
  end

  // job to the queue
  assign push           = s1_valid;
  assign push_job.flush = s1_flush;
  assign push_job.code  = s1_flush ? '0 : rd_entry.code;
  assign push_job.len   = s1_flush ? '0 : rd_entry.len;

endmodule

>>> rtl/hcbp_fifo.sv
// short job queue between front and back end
module hcbp_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  hcbp_pkg::job_t                  push_job,
  input  logic                            pop,
  output logic                            head_valid,
  output hcbp_pkg::job_t                  head,
  output logic [hcbp_pkg::QCNT_BITS-1:0]  count
);

  hcbp_pkg::job_t                slots [hcbp_pkg::QDEPTH];
  logic [hcbp_pkg::QAW-1:0]      wr_ptr;
  logic [hcbp_pkg::QAW-1:0]      rd_ptr;

  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + hcbp_pkg::QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + hcbp_pkg::QAW'(1);
      end
      if (push && !pop) begin
        count <= count + hcbp_pkg::QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - hcbp_pkg::QCNT_BITS'(1);
      end
    end
  end

endmodule

>>> rtl/hcbp_back.sv
// back end: packs code bits msb first into bytes and drives the output register
module hcbp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  hcbp_pkg::job_t        head,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // out_byte [7:0]
  output logic [7:0]            m_tdata,
  output logic                  m_tlast
);

  logic [hcbp_pkg::BUF_BITS-1:0]  bit_buf;
  logic [hcbp_pkg::BUF_BITS-1:0]  bit_buf_next;
  logic [hcbp_pkg::BUF_BITS-1:0]  buf_rem;
  logic [hcbp_pkg::CNT_BITS-1:0]  cnt;
  logic [hcbp_pkg::CNT_BITS-1:0]  cnt_next;
  logic [hcbp_pkg::CNT_BITS-1:0]  cnt_rem;
  logic                           slot_free;
  logic                           emit_full;
  logic                           emit_flush;
  logic                           pop_enc;
  logic                           pop_flush;

  // output slot can take a byte this cycle
  assign slot_free = !m_tvalid || m_tready;
  assign emit_full = slot_free && (cnt >= hcbp_pkg::CNT_BITS'(hcbp_pkg::BYTE_BITS));

  // buffer after a possible full-byte emit
  assign cnt_rem = emit_full ? cnt - hcbp_pkg::CNT_BITS'(hcbp_pkg::BYTE_BITS) : cnt;
  assign buf_rem = emit_full ? (bit_buf << hcbp_pkg::BYTE_BITS) : bit_buf;

  // job selection: append a code once under a byte is left, flush when no full byte waits
  assign pop_enc    = head_valid && !head.flush
                      && (cnt_rem < hcbp_pkg::CNT_BITS'(hcbp_pkg::BYTE_BITS));
  assign pop_flush  = head_valid && head.flush && slot_free
                      && (cnt < hcbp_pkg::CNT_BITS'(hcbp_pkg::BYTE_BITS));
  assign emit_flush = pop_flush && (cnt != '0);
  assign pop        = pop_enc || pop_flush;

  // bit buffer next state
  always_comb begin
    if (pop_flush) begin
      bit_buf_next = '0;
      cnt_next     = '0;
    end else if (pop_enc) begin
      bit_buf_next = buf_rem | ({head.code, hcbp_pkg::BYTE_BITS'(0)} >> cnt_rem);
      cnt_next     = cnt_rem + hcbp_pkg::CNT_BITS'(head.len);
    end else begin
      bit_buf_next = buf_rem;
      cnt_next     = cnt_rem;
    end
  end

  // bit buffer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buf <= '0;
      cnt     <= '0;
    end else begin
      bit_buf <= bit_buf_next;
      cnt     <= cnt_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_full || emit_flush) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_full || emit_flush) begin
      m_tdata <= bit_buf[hcbp_pkg::BUF_BITS-1 -: hcbp_pkg::BYTE_BITS];
      m_tlast <= emit_flush;
    end
  end

endmodule

>>> rtl/huffman_code_bit_packer.sv
// top level of the huffman code bit packer: front end, job queue and back end
//
// Input stream s_*: one command per transfer, command in s_tuser. A load writes
// a symbol's code (right-aligned bits, length saturated to 32) into the code
// table, an encode appends the symbol's code msb first, a flush emits the
// partial byte zero-padded with m_tlast high. A load is visible to an encode
// issued on the very next cycle.
// Output stream m_*: one packed byte per transfer, first code bit in bit 7.
// Path: a byte completed by an encode passes the registered table read, the job
// queue, the bit buffer and the output register. Throughput: one command per
// cycle while s_tready is high; unstalled, the back end emits one byte per cycle
// and takes a new code once fewer than eight bits wait, so codes of up to eight
// bits sustain one symbol per cycle; longer codes delay the next as bytes drain.
// The four-entry job queue decouples table lookup from packing; s_tready drops
// when the queue plus the lookup in flight would fill it.
// Stall: with m_tready low the output register holds, the queue fills and
// s_tready falls; nothing is dropped.
// Reset: rst clears the queue, the bit buffer and the output valid; the code
// table keeps no reset value and must be loaded before symbols are encoded.
module huffman_code_bit_packer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // symbol [7:0], code_bits [39:8], code_length [45:40], zero [47:46]
  input  logic [hcbp_pkg::S_DATA_BITS-1:0]  s_tdata,
  // command [1:0]
  input  logic [hcbp_pkg::CMD_BITS-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // out_byte [7:0]
  output logic [7:0]                        m_tdata,
  output logic                              m_tlast
);

  logic                                  push;
  hcbp_pkg::job_t                        push_job;
  logic                                  pop;
  logic                                  head_valid;
  hcbp_pkg::job_t                        head;
  logic [hcbp_pkg::QCNT_BITS-1:0]        q_count;

  // command intake and table lookup
  hcbp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_count  (q_count),
    .push     (push),
    .push_job (push_job)
  );

  // job queue
  hcbp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (q_count)
  );

  // bit packing and output
  hcbp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

>>> bench/huffman_code_bit_packer_tb.sv
// self-checking testbench for the huffman code bit packer: random stream traffic against a predictor
module huffman_code_bit_packer_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // command code the block ignores
  localparam logic [hcbp_pkg::CMD_BITS-1:0] CMD_SPARE = 2'd3;
  localparam int IDLE_PCT = 29;
  localparam int RAND_CMDS = 434;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [hcbp_pkg::CMD_BITS-1:0]  cmd;
    logic [hcbp_pkg::SYM_BITS-1:0]  sym;
    logic [hcbp_pkg::CODE_BITS-1:0] bits;
    logic [hcbp_pkg::LEN_BITS-1:0]  len;
  } pk_cmd_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } pk_byte_t;

  logic                             clk;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [hcbp_pkg::S_DATA_BITS-1:0] s_tdata;
  logic [hcbp_pkg::CMD_BITS-1:0]    s_tuser;
  logic                             m_tvalid;
  logic                             m_tready;
  logic [7:0]                       m_tdata;
  logic                             m_tlast;

  huffman_code_bit_packer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // stimulus and expectation stores
  pk_cmd_t  cmd_q[$];
  pk_byte_t byte_q[$];
  pk_cmd_t  cur_cmd;
  pk_cmd_t  next_cmd;
  logic     s_took;
  int       n_pushed;
  int       n_taken;
  int       n_errors;
  logic     calm;

  // predictor state
  logic [hcbp_pkg::CODE_BITS-1:0] tab_bits [hcbp_pkg::ALPHABET_SIZE];
  logic [hcbp_pkg::LEN_BITS-1:0]  tab_len [hcbp_pkg::ALPHABET_SIZE];
  logic [7:0]                     pend_byte;
  int                             free_cnt;

  // stimulus-side view of which symbols hold a code
  logic [hcbp_pkg::SYM_BITS-1:0]  loaded_syms[$];
  bit                             is_loaded [hcbp_pkg::ALPHABET_SIZE];

  // no idling on either side for a long stretch in the random part
  assign calm = (n_taken >= 200) && (n_taken < 330);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // apply one accepted command to the predictor, queue the bytes it produces
  task automatic pack_cmd(input pk_cmd_t c);
    logic [hcbp_pkg::LEN_BITS-1:0] l;
    if (c.cmd == hcbp_pkg::CMD_LOAD) begin
      l = (c.len > hcbp_pkg::CODE_LIMIT) ? hcbp_pkg::LEN_BITS'(hcbp_pkg::CODE_LIMIT) : c.len;
      tab_len[c.sym]  = l;
      tab_bits[c.sym] = c.bits & hcbp_pkg::CODE_BITS'((64'd1 << l) - 64'd1);
    end else if (c.cmd == hcbp_pkg::CMD_ENCODE) begin
      // msb of the code goes first, byte fills from bit 7 down
      for (int i = int'(tab_len[c.sym]) - 1; i >= 0; i--) begin
        if (tab_bits[c.sym][i])
          pend_byte[free_cnt-1] = 1'b1;
        free_cnt--;
        if (free_cnt == 0) begin
          byte_q.push_back('{data: pend_byte, last: 1'b0});
          pend_byte = '0;
          free_cnt  = hcbp_pkg::BYTE_BITS;
        end
      end
    end else if (c.cmd == hcbp_pkg::CMD_FLUSH) begin
      if (free_cnt < hcbp_pkg::BYTE_BITS)
        byte_q.push_back('{data: pend_byte, last: 1'b1});
      pend_byte = '0;
      free_cnt  = hcbp_pkg::BYTE_BITS;
    end
  endtask

  function automatic void queue_cmd(input logic [hcbp_pkg::CMD_BITS-1:0] cmd,
                                    input int unsigned sym,
                                    input int unsigned bits,
                                    input int unsigned len);
    logic [hcbp_pkg::SYM_BITS-1:0] s;
    s = hcbp_pkg::SYM_BITS'(sym);
    cmd_q.push_back('{cmd: cmd, sym: s, bits: hcbp_pkg::CODE_BITS'(bits),
                      len: hcbp_pkg::LEN_BITS'(len)});
    n_pushed++;
    if (cmd == hcbp_pkg::CMD_LOAD && !is_loaded[s]) begin
      is_loaded[s] = 1'b1;
      loaded_syms.push_back(s);
    end
  endfunction

  // driver: new command and ready at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || s_took) begin
        if (cmd_q.size() != 0 && (calm || $urandom_range(99, 0) >= IDLE_PCT)) begin
          next_cmd = cmd_q.pop_front();
          cur_cmd  = next_cmd;
          s_tdata  <= {2'b00, next_cmd.len, next_cmd.bits, next_cmd.sym};
          s_tuser  <= next_cmd.cmd;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
    end
  end

  // monitor: output check and input acceptance at the rising edge
  always @(posedge clk) begin
    s_took <= !rst && s_tvalid && (s_tready === 1'b1);
    if (!rst) begin
      if (m_tvalid === 1'b1 && m_tready) begin
        if (byte_q.size() == 0) begin
          flag_error($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
        end else begin
          automatic pk_byte_t exp_b = byte_q.pop_front();
          if (m_tdata !== exp_b.data)
            flag_error($sformatf("out_byte %02h, expected %02h", m_tdata, exp_b.data));
          if (m_tlast !== exp_b.last)
            flag_error($sformatf("last %0b, expected %0b", m_tlast, exp_b.last));
        end
      end
      if (s_tvalid && s_tready === 1'b1) begin
        pack_cmd(cur_cmd);
        n_taken++;
      end
    end
  end

  // timeout
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int n_real;
    int r;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    m_tready = 1'b0;
    s_took   = 1'b0;
    n_pushed = 0;
    n_taken  = 0;
    n_errors = 0;
    pend_byte = '0;
    free_cnt  = hcbp_pkg::BYTE_BITS;
    foreach (is_loaded[i]) is_loaded[i] = 1'b0;

    // directed: extreme codes and lengths, zero length, empty flush, spare command
    queue_cmd(hcbp_pkg::CMD_LOAD, 0, 'hFFFF_FFFF, 32);
    queue_cmd(hcbp_pkg::CMD_LOAD, 255, 'h0000_0000, 1);
    queue_cmd(hcbp_pkg::CMD_LOAD, 1, 'hFFFF_FFFF, 63);
    queue_cmd(hcbp_pkg::CMD_LOAD, 2, 'h0000_00A5, 0);
    queue_cmd(hcbp_pkg::CMD_LOAD, 3, 'h0000_0005, 3);
    queue_cmd(hcbp_pkg::CMD_LOAD, 4, 'hDEAD_BEEF, 40);
    queue_cmd(hcbp_pkg::CMD_FLUSH, $urandom, $urandom, $urandom);
    queue_cmd(hcbp_pkg::CMD_ENCODE, 2, $urandom, $urandom);
    queue_cmd(hcbp_pkg::CMD_ENCODE, 3, $urandom, $urandom);
    queue_cmd(hcbp_pkg::CMD_FLUSH, $urandom, $urandom, $urandom);
    queue_cmd(hcbp_pkg::CMD_ENCODE, 0, $urandom, $urandom);
    queue_cmd(hcbp_pkg::CMD_ENCODE, 3, $urandom, $urandom);
    queue_cmd(hcbp_pkg::CMD_ENCODE, 0, $urandom, $urandom);
    queue_cmd(CMD_SPARE, $urandom, $urandom, $urandom);
    queue_cmd(hcbp_pkg::CMD_ENCODE, 1, $urandom, $urandom);
    repeat (5) queue_cmd(hcbp_pkg::CMD_ENCODE, 255, $urandom, $urandom);
    queue_cmd(hcbp_pkg::CMD_ENCODE, 4, $urandom, $urandom);
    queue_cmd(hcbp_pkg::CMD_FLUSH, $urandom, $urandom, $urandom);
    queue_cmd(hcbp_pkg::CMD_FLUSH, $urandom, $urandom, $urandom);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // hold off the random part until the directed bytes are all out
    wait (n_taken == n_pushed && byte_q.size() == 0);

    // random: mostly encodes of loaded symbols, some loads, flushes and noise
    n_real = 0;
    while (n_real < RAND_CMDS) begin
      r = $urandom_range(99, 0);
      if (r < 12) begin
        r = $urandom_range(99, 0);
        queue_cmd(hcbp_pkg::CMD_LOAD, $urandom_range(255, 0), $urandom,
                  (r < 85) ? $urandom_range(9, 1) :
                  (r < 95) ? $urandom_range(32, 10) : $urandom_range(63, 0));
      end else if (r < 82) begin
        queue_cmd(hcbp_pkg::CMD_ENCODE,
                  {24'd0, loaded_syms[$urandom_range(loaded_syms.size() - 1, 0)]},
                  $urandom, $urandom);
      end else if (r < 94) begin
        queue_cmd(hcbp_pkg::CMD_FLUSH, $urandom, $urandom, $urandom);
      end else begin
        queue_cmd(CMD_SPARE, $urandom, $urandom, $urandom);
      end
      n_real++;
    end
    queue_cmd(hcbp_pkg::CMD_FLUSH, $urandom, $urandom, $urandom);

    // drain and watch for stray bytes
    wait (n_taken == n_pushed);
    wait (byte_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
